// File: rtl/delimited_record_field_extractor_macros.svh
// ----------------------------------------------------------------------------
// delimited record field extractor assertion macros
// property check wrappers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef DELIMITED_RECORD_FIELD_EXTRACTOR_MACROS_SVH
`define DELIMITED_RECORD_FIELD_EXTRACTOR_MACROS_SVH

`ifndef SYNTHESIS

`define DRFE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

`define DRFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next cycle check failed");

`else

`define DRFE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`define DRFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/drfe_pkg.sv
// ----------------------------------------------------------------------------
// drfe_pkg
// shared types and constants of the delimited record field extractor
// ----------------------------------------------------------------------------
package drfe_pkg;

    localparam logic [7:0] CH_END      = 8'h00;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_COMMA    = 8'h2C;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_RBRACE   = 8'h7D;

    localparam logic [1:0] CFG_RECORD_COUNT = 2'd0;
    localparam logic [1:0] CFG_PRICE_LIMIT  = 2'd1;
    localparam logic [1:0] CFG_TIME_LIMIT   = 2'd2;

    localparam logic [7:0] RECORD_COUNT_RST = 8'd24;
    localparam logic [5:0] PRICE_LIMIT_RST  = 6'd16;
    localparam logic [5:0] TIME_LIMIT_RST   = 6'd32;

    typedef enum logic [2:0] {
        KIND_PRICE_CHAR = 3'd0,
        KIND_TIME_CHAR  = 3'd1,
        KIND_PRICE_END  = 3'd2,
        KIND_TIME_END   = 3'd3,
        KIND_RECORD_END = 3'd4,
        KIND_OK         = 3'd5,
        KIND_FAILED     = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_END   = 2'd1,
        ERR_PRICE = 2'd2,
        ERR_TIME  = 2'd3
    } t_err;

    typedef struct packed {
        logic [7:0] record_count;
        logic [5:0] price_limit;
        logic [5:0] time_limit;
    } t_cfg;

    typedef struct packed {
        logic       vld;
        t_kind      kind;
        logic [7:0] ch;
        logic [7:0] idx;
        t_err       err;
    } t_result;

endpackage

// File: rtl/drfe_parser.sv
// ----------------------------------------------------------------------------
// drfe_parser
// parse state and one-byte step logic, gives at most one result per byte
// ----------------------------------------------------------------------------
module drfe_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_byte,
    input  drfe_pkg::t_cfg    i_cfg,
    output drfe_pkg::t_result o_res
);

    typedef enum logic [3:0] {
        PH_SEEK_BRACKET = 4'd0,
        PH_SEEK_PCOLON  = 4'd1,
        PH_PRICE        = 4'd2,
        PH_SEEK_TCOLON  = 4'd3,
        PH_SEEK_QUOTE   = 4'd4,
        PH_TIME         = 4'd5,
        PH_SEEK_BRACE   = 4'd6,
        PH_DRAIN_OK     = 4'd7,
        PH_DRAIN_ERR    = 4'd8
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [5:0]      r_len, n_len;
    logic [7:0]      r_done, n_done;
    drfe_pkg::t_err  r_perr, n_perr;
    logic [6:0]      len_inc;
    logic [7:0]      done_inc;

    assign len_inc  = {1'b0, r_len} + 7'd1;
    assign done_inc = r_done + 8'd1;

    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_done    = r_done;
        n_perr    = r_perr;
        o_res     = '0;
        o_res.idx = r_done;
        if (i_byte == drfe_pkg::CH_END) begin
            o_res.vld = 1'b1;
            n_phase   = PH_SEEK_BRACKET;
            n_len     = '0;
            n_done    = '0;
            n_perr    = drfe_pkg::ERR_NONE;
            if (r_phase == PH_DRAIN_OK) begin
                o_res.kind = drfe_pkg::KIND_OK;
                o_res.idx  = '0;
            end else begin
                o_res.kind = drfe_pkg::KIND_FAILED;
                if (r_phase == PH_DRAIN_ERR && r_perr != drfe_pkg::ERR_NONE) begin
                    o_res.err = r_perr;
                end else begin
                    o_res.err = drfe_pkg::ERR_END;
                end
            end
        end else begin
            case (r_phase)
                PH_SEEK_BRACKET: begin
                    if (i_byte == drfe_pkg::CH_LBRACKET) begin
                        n_phase = (r_done >= i_cfg.record_count) ? PH_DRAIN_OK
                                                                 : PH_SEEK_PCOLON;
                    end
                end
                PH_SEEK_PCOLON: begin
                    if (i_byte == drfe_pkg::CH_COLON) begin
                        n_phase = PH_PRICE;
                        n_len   = '0;
                    end
                end
                PH_PRICE: begin
                    if (i_byte == drfe_pkg::CH_COMMA) begin
                        n_phase    = PH_SEEK_TCOLON;
                        n_len      = '0;
                        o_res.vld  = 1'b1;
                        o_res.kind = drfe_pkg::KIND_PRICE_END;
                    end else if (len_inc >= {1'b0, i_cfg.price_limit}) begin
                        n_phase = PH_DRAIN_ERR;
                        n_perr  = drfe_pkg::ERR_PRICE;
                        n_len   = '0;
                    end else begin
                        n_len      = len_inc[5:0];
                        o_res.vld  = 1'b1;
                        o_res.kind = drfe_pkg::KIND_PRICE_CHAR;
                        o_res.ch   = i_byte;
                    end
                end
                PH_SEEK_TCOLON: begin
                    if (i_byte == drfe_pkg::CH_COLON) begin
                        n_phase = PH_SEEK_QUOTE;
                    end
                end
                PH_SEEK_QUOTE: begin
                    if (i_byte == drfe_pkg::CH_QUOTE) begin
                        n_phase = PH_TIME;
                        n_len   = '0;
                    end
                end
                PH_TIME: begin
                    if (i_byte == drfe_pkg::CH_COLON) begin
                        n_phase    = PH_SEEK_BRACE;
                        n_len      = '0;
                        o_res.vld  = 1'b1;
                        o_res.kind = drfe_pkg::KIND_TIME_END;
                    end else if (len_inc >= {1'b0, i_cfg.time_limit}) begin
                        n_phase = PH_DRAIN_ERR;
                        n_perr  = drfe_pkg::ERR_TIME;
                        n_len   = '0;
                    end else begin
                        n_len      = len_inc[5:0];
                        o_res.vld  = 1'b1;
                        o_res.kind = drfe_pkg::KIND_TIME_CHAR;
                        o_res.ch   = i_byte;
                    end
                end
                PH_SEEK_BRACE: begin
                    if (i_byte == drfe_pkg::CH_RBRACE) begin
                        n_done     = done_inc;
                        n_phase    = (done_inc >= i_cfg.record_count) ? PH_DRAIN_OK
                                                                      : PH_SEEK_PCOLON;
                        o_res.vld  = 1'b1;
                        o_res.kind = drfe_pkg::KIND_RECORD_END;
                    end
                end
                PH_DRAIN_OK, PH_DRAIN_ERR: begin
                    n_phase = r_phase;
                end
                default: begin
                    n_phase = PH_SEEK_BRACKET;
                    n_len   = '0;
                    n_done  = '0;
                    n_perr  = drfe_pkg::ERR_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SEEK_BRACKET;
            r_len   <= '0;
            r_done  <= '0;
            r_perr  <= drfe_pkg::ERR_NONE;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_done  <= n_done;
            r_perr  <= n_perr;
        end
    end

endmodule

// File: rtl/delimited_record_field_extractor.sv
// ----------------------------------------------------------------------------
// delimited_record_field_extractor
// pulls price and time fields out of a delimited response, one byte per item
//
//   channel  direction  handshake                  payload
//   in       in         i_in_valid / o_in_stall    i_in_byte
//   out      out        o_out_valid / i_out_stall  o_kind, o_out_char,
//                                                  o_record_index, o_error_code
//   cfg      in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// one byte per cycle sustained when the output does not stall; an accepted byte
// waits in the input register, its result, if any, in the result register
// synchronous active-low reset restarts the parse and loads default limits
// an output stall holds the result register, then backs up the input register
// ----------------------------------------------------------------------------
`include "delimited_record_field_extractor_macros.svh"

module delimited_record_field_extractor (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_kind,
    output logic [7:0] o_out_char,
    output logic [7:0] o_record_index,
    output logic [1:0] o_error_code,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    drfe_pkg::t_cfg    r_cfg;
    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    drfe_pkg::t_result r_out;
    drfe_pkg::t_result step_res;
    logic              step_go;
    logic              in_take;

    // byte moves to the result register once that register is free
    assign step_go    = r_in_valid && (!r_out.vld || !i_out_stall);
    assign o_in_stall = r_in_valid && !step_go;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.record_count <= drfe_pkg::RECORD_COUNT_RST;
            r_cfg.price_limit  <= drfe_pkg::PRICE_LIMIT_RST;
            r_cfg.time_limit   <= drfe_pkg::TIME_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                drfe_pkg::CFG_RECORD_COUNT: r_cfg.record_count <= i_cfg_data;
                drfe_pkg::CFG_PRICE_LIMIT:  r_cfg.price_limit  <= i_cfg_data[5:0];
                drfe_pkg::CFG_TIME_LIMIT:   r_cfg.time_limit   <= i_cfg_data[5:0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step_go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in_byte;
        end
    end

    drfe_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step_go),
        .i_byte  (r_in_byte),
        .i_cfg   (r_cfg),
        .o_res   (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out <= '0;
        end else if (step_go) begin
            r_out <= step_res;
        end else if (!i_out_stall) begin
            r_out.vld <= 1'b0;
        end
    end

    assign o_out_valid    = r_out.vld;
    assign o_kind         = r_out.kind;
    assign o_out_char     = r_out.ch;
    assign o_record_index = r_out.idx;
    assign o_error_code   = r_out.err;

    `DRFE_ASSERT_IMPLY(a_err_only_failed, i_clk, i_rst_n,
        o_out_valid && r_out.kind != drfe_pkg::KIND_FAILED,
        r_out.err == drfe_pkg::ERR_NONE)
    `DRFE_ASSERT_IMPLY(a_char_only_fields, i_clk, i_rst_n,
        o_out_valid && o_out_char != 8'd0,
        r_out.kind == drfe_pkg::KIND_PRICE_CHAR || r_out.kind == drfe_pkg::KIND_TIME_CHAR)
    `DRFE_ASSERT_IMPLY(a_ok_clean, i_clk, i_rst_n,
        o_out_valid && r_out.kind == drfe_pkg::KIND_OK,
        o_record_index == 8'd0 && o_out_char == 8'd0)
    `DRFE_ASSERT_NEXT(a_backup_holds, i_clk, i_rst_n,
        r_in_valid && r_out.vld && i_out_stall,
        r_in_valid)

endmodule

// File: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench for delimited_record_field_extractor
// scripted rows with typed results, then random responses over several
// register settings, each result checked against its typed result or a byte scanner model
// ----------------------------------------------------------------------------
module testbench;

    localparam int         CLK_HALF    = 6;
    localparam int         BYTE_TARGET = 1450;
    localparam logic [1:0] CFG_SPARE   = 2'd3;

    typedef enum logic [3:0] {
        S_FIND_BRACKET,
        S_FIND_PCOLON,
        S_PRICE,
        S_FIND_TCOLON,
        S_FIND_QUOTE,
        S_TIME,
        S_FIND_BRACE,
        S_TRAIL_OK,
        S_TRAIL_ERR
    } t_scan;

    typedef struct {
        bit                is_cfg;
        logic [1:0]        reg_idx;
        logic [7:0]        value;
        bit                typed;
        drfe_pkg::t_result want;
    } t_stim_row;

    logic       i_clk          = 1'b0;
    logic       i_rst_n        = 1'b0;
    logic       i_in_valid     = 1'b0;
    logic [7:0] i_in_byte      = 8'h00;
    logic       i_out_stall    = 1'b0;
    logic       i_cfg_we       = 1'b0;
    logic [1:0] i_cfg_index    = 2'd0;
    logic [7:0] i_cfg_data     = 8'h00;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [2:0] o_kind;
    logic [7:0] o_out_char;
    logic [7:0] o_record_index;
    logic [1:0] o_error_code;

    // scanner model state and its copy of the registers
    t_scan          scan_st;
    logic [5:0]     fld_len;
    logic [7:0]     recs_done;
    drfe_pkg::t_err held_err;
    logic [7:0]     lim_records;
    logic [5:0]     lim_price;
    logic [5:0]     lim_time;

    t_stim_row         script[$];
    t_stim_row         byte_rows[$];
    drfe_pkg::t_result extracted_q[$];

    int src_idle_pct   = 17;
    int sink_stall_pct = 61;
    int sent_bytes     = 0;
    int checked        = 0;
    int errors         = 0;
    int n_ok           = 0;
    int n_failed       = 0;
    int cfg_writes     = 0;

    delimited_record_field_extractor u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_byte      (i_in_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_out_char     (o_out_char),
        .o_record_index (o_record_index),
        .o_error_code   (o_error_code),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #(CLK_HALF * 2 * 400_000);
        $display("%0t: timeout", $time);
        $display("Verification failed");
        $finish;
    end

    function automatic void scan_restart();
        scan_st   = S_FIND_BRACKET;
        fld_len   = '0;
        recs_done = '0;
        held_err  = drfe_pkg::ERR_NONE;
    endfunction

    function automatic void scan_fail(input drfe_pkg::t_err code);
        held_err = code;
        scan_st  = S_TRAIL_ERR;
        fld_len  = '0;
    endfunction

    function automatic drfe_pkg::t_result scan_byte(input logic [7:0] b);
        drfe_pkg::t_result r;
        r = '0;
        r.idx = recs_done;
        if (b == drfe_pkg::CH_END) begin
            r.vld = 1'b1;
            if (scan_st == S_TRAIL_OK) begin
                r.kind = drfe_pkg::KIND_OK;
                r.idx  = '0;
            end else begin
                r.kind = drfe_pkg::KIND_FAILED;
                if (scan_st == S_TRAIL_ERR && held_err != drfe_pkg::ERR_NONE)
                    r.err = held_err;
                else
                    r.err = drfe_pkg::ERR_END;
            end
            scan_restart();
            return r;
        end
        case (scan_st)
            S_FIND_BRACKET: begin
                if (b == drfe_pkg::CH_LBRACKET)
                    scan_st = (recs_done >= lim_records) ? S_TRAIL_OK : S_FIND_PCOLON;
            end
            S_FIND_PCOLON: begin
                if (b == drfe_pkg::CH_COLON) begin
                    scan_st = S_PRICE;
                    fld_len = '0;
                end
            end
            S_PRICE: begin
                if (b == drfe_pkg::CH_COMMA) begin
                    scan_st = S_FIND_TCOLON;
                    fld_len = '0;
                    r.vld   = 1'b1;
                    r.kind  = drfe_pkg::KIND_PRICE_END;
                end else if (int'(fld_len) + 1 >= int'(lim_price)) begin
                    scan_fail(drfe_pkg::ERR_PRICE);
                end else begin
                    fld_len = fld_len + 6'd1;
                    r.vld   = 1'b1;
                    r.kind  = drfe_pkg::KIND_PRICE_CHAR;
                    r.ch    = b;
                end
            end
            S_FIND_TCOLON: begin
                if (b == drfe_pkg::CH_COLON) scan_st = S_FIND_QUOTE;
            end
            S_FIND_QUOTE: begin
                if (b == drfe_pkg::CH_QUOTE) begin
                    scan_st = S_TIME;
                    fld_len = '0;
                end
            end
            S_TIME: begin
                if (b == drfe_pkg::CH_COLON) begin
                    scan_st = S_FIND_BRACE;
                    fld_len = '0;
                    r.vld   = 1'b1;
                    r.kind  = drfe_pkg::KIND_TIME_END;
                end else if (int'(fld_len) + 1 >= int'(lim_time)) begin
                    scan_fail(drfe_pkg::ERR_TIME);
                end else begin
                    fld_len = fld_len + 6'd1;
                    r.vld   = 1'b1;
                    r.kind  = drfe_pkg::KIND_TIME_CHAR;
                    r.ch    = b;
                end
            end
            S_FIND_BRACE: begin
                if (b == drfe_pkg::CH_RBRACE) begin
                    r.vld     = 1'b1;
                    r.kind    = drfe_pkg::KIND_RECORD_END;
                    recs_done = recs_done + 8'd1;
                    scan_st   = (recs_done >= lim_records) ? S_TRAIL_OK : S_FIND_PCOLON;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // accepted bytes feed the scanner model
    always @(posedge i_clk) begin
        t_stim_row         row;
        drfe_pkg::t_result want;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            row  = byte_rows.pop_front();
            want = scan_byte(i_in_byte);
            sent_bytes++;
            if (row.typed) want = row.want;
            if (want.vld) extracted_q.push_back(want);
        end
    end

    function automatic void report_field(input string name, input logic [7:0] want_v,
                                         input logic [7:0] got_v);
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
    endfunction

    always @(posedge i_clk) begin
        drfe_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (extracted_q.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, expected none, actual kind %0d",
                         $time, o_kind);
            end else begin
                want = extracted_q.pop_front();
                checked++;
                if (o_kind !== want.kind)
                    report_field("kind", 8'(want.kind), 8'(o_kind));
                if (o_out_char !== want.ch)
                    report_field("char", want.ch, o_out_char);
                if (o_record_index !== want.idx)
                    report_field("record index", want.idx, o_record_index);
                if (o_error_code !== want.err)
                    report_field("error code", 8'(want.err), 8'(o_error_code));
                if (want.kind == drfe_pkg::KIND_OK) n_ok++;
                else if (want.kind == drfe_pkg::KIND_FAILED) n_failed++;
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end

    function automatic void add_byte(input logic [7:0] b);
        t_stim_row row;
        row = '{is_cfg: 1'b0, reg_idx: 2'd0, value: b, typed: 1'b0, want: '0};
        script.push_back(row);
    endfunction

    function automatic void add_result(input logic [7:0] b, input drfe_pkg::t_kind kind,
                                       input logic [7:0] ch, input logic [7:0] idx,
                                       input drfe_pkg::t_err err);
        t_stim_row row;
        row = '{is_cfg: 1'b0, reg_idx: 2'd0, value: b, typed: 1'b1,
                want: '{vld: 1'b1, kind: kind, ch: ch, idx: idx, err: err}};
        script.push_back(row);
    endfunction

    function automatic void add_reg(input logic [1:0] idx, input logic [7:0] val);
        t_stim_row row;
        row = '{is_cfg: 1'b1, reg_idx: idx, value: val, typed: 1'b0, want: '0};
        script.push_back(row);
    endfunction

    task automatic push_byte(input t_stim_row row);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_rows.push_back(row);
        i_in_valid <= 1'b1;
        i_in_byte  <= row.value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // drain every result, then let bytes with no result leave the pipe
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (extracted_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        case (idx)
            drfe_pkg::CFG_RECORD_COUNT: lim_records = val;
            drfe_pkg::CFG_PRICE_LIMIT:  lim_price   = val[5:0];
            drfe_pkg::CFG_TIME_LIMIT:   lim_time    = val[5:0];
            default: ;
        endcase
        cfg_writes++;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] filler(input logic [7:0] avoid);
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0: b = drfe_pkg::CH_COMMA;
            1: b = drfe_pkg::CH_COLON;
            2: b = drfe_pkg::CH_QUOTE;
            3: b = drfe_pkg::CH_RBRACE;
            4: b = drfe_pkg::CH_LBRACKET;
            default: b = 8'($urandom_range(1, 255));
        endcase
        if (b == avoid || b == drfe_pkg::CH_END) b = 8'h41;
        return b;
    endfunction

    function automatic int pick_len(input int lim);
        if ($urandom_range(0, 4) == 0) return $urandom_range(0, lim + 1);
        return $urandom_range(0, (lim > 6) ? 5 : lim - 1);
    endfunction

    task automatic add_field(ref logic [7:0] q[$], input logic [7:0] lead,
                             input logic [7:0] delim, input int lim);
        int n;
        repeat ($urandom_range(0, 2)) q.push_back(filler(lead));
        q.push_back(lead);
        n = pick_len(lim);
        repeat (n) q.push_back(filler(delim));
        q.push_back(delim);
    endtask

    task automatic build_response(ref logic [7:0] q[$]);
        int n_rec;
        int cut;
        q.delete();
        if ($urandom_range(0, 9) == 0) begin
            // noise, may leave the scanner mid response
            repeat ($urandom_range(1, 12))
                q.push_back(($urandom_range(0, 6) == 0) ? drfe_pkg::CH_END
                                                        : filler(drfe_pkg::CH_END));
            return;
        end
        repeat ($urandom_range(0, 2)) q.push_back(filler(drfe_pkg::CH_LBRACKET));
        q.push_back(drfe_pkg::CH_LBRACKET);
        if (lim_records > 6)
            n_rec = $urandom_range(0, 6);
        else if ($urandom_range(0, 6) == 0)
            n_rec = $urandom_range(0, int'(lim_records) - 1);
        else
            n_rec = int'(lim_records);
        repeat (n_rec) begin
            add_field(q, drfe_pkg::CH_COLON, drfe_pkg::CH_COMMA, int'(lim_price));
            repeat ($urandom_range(0, 2)) q.push_back(filler(drfe_pkg::CH_COLON));
            q.push_back(drfe_pkg::CH_COLON);
            add_field(q, drfe_pkg::CH_QUOTE, drfe_pkg::CH_COLON, int'(lim_time));
            repeat ($urandom_range(0, 2)) q.push_back(filler(drfe_pkg::CH_RBRACE));
            q.push_back(drfe_pkg::CH_RBRACE);
        end
        repeat ($urandom_range(0, 2)) q.push_back(filler(drfe_pkg::CH_END));
        if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(1, q.size());
            q   = q[0:cut-1];
        end
        q.push_back(drfe_pkg::CH_END);
    endtask

    initial begin
        logic [7:0] resp[$];
        t_stim_row  row;
        int         phase_no;
        int         phase_mark;
        logic [7:0] rc;
        logic [7:0] pl;
        logic [7:0] tl;

        scan_restart();
        lim_records = drfe_pkg::RECORD_COUNT_RST;
        lim_price   = drfe_pkg::PRICE_LIMIT_RST;
        lim_time    = drfe_pkg::TIME_LIMIT_RST;

        // reset limits: end before '[', then one record and an early end
        add_result(drfe_pkg::CH_END, drfe_pkg::KIND_FAILED, 8'h00, 8'd0,
                   drfe_pkg::ERR_END);
        add_byte(drfe_pkg::CH_LBRACKET);
        add_byte(drfe_pkg::CH_COLON);
        add_result(8'hFF, drfe_pkg::KIND_PRICE_CHAR, 8'hFF, 8'd0, drfe_pkg::ERR_NONE);
        add_result(drfe_pkg::CH_COMMA, drfe_pkg::KIND_PRICE_END, 8'h00, 8'd0,
                   drfe_pkg::ERR_NONE);
        add_byte(drfe_pkg::CH_COLON);
        add_byte(drfe_pkg::CH_QUOTE);
        add_result(8'h31, drfe_pkg::KIND_TIME_CHAR, 8'h31, 8'd0, drfe_pkg::ERR_NONE);
        add_result(drfe_pkg::CH_COLON, drfe_pkg::KIND_TIME_END, 8'h00, 8'd0,
                   drfe_pkg::ERR_NONE);
        add_result(drfe_pkg::CH_RBRACE, drfe_pkg::KIND_RECORD_END, 8'h00, 8'd0,
                   drfe_pkg::ERR_NONE);
        add_result(drfe_pkg::CH_END, drfe_pkg::KIND_FAILED, 8'h00, 8'd1,
                   drfe_pkg::ERR_END);
        add_reg(drfe_pkg::CFG_RECORD_COUNT, 8'd1);
        add_reg(drfe_pkg::CFG_PRICE_LIMIT, 8'd1);
        add_reg(drfe_pkg::CFG_TIME_LIMIT, 8'd1);
        add_reg(CFG_SPARE, 8'h00);
        // price character at the limit, then drain
        add_byte(drfe_pkg::CH_LBRACKET);
        add_byte(drfe_pkg::CH_COLON);
        add_byte(8'h41);
        add_result(drfe_pkg::CH_END, drfe_pkg::KIND_FAILED, 8'h00, 8'd0,
                   drfe_pkg::ERR_PRICE);
        // empty fields, trailing byte ignored, success
        add_byte(drfe_pkg::CH_LBRACKET);
        add_byte(drfe_pkg::CH_COLON);
        add_result(drfe_pkg::CH_COMMA, drfe_pkg::KIND_PRICE_END, 8'h00, 8'd0,
                   drfe_pkg::ERR_NONE);
        add_byte(drfe_pkg::CH_COLON);
        add_byte(drfe_pkg::CH_QUOTE);
        add_result(drfe_pkg::CH_COLON, drfe_pkg::KIND_TIME_END, 8'h00, 8'd0,
                   drfe_pkg::ERR_NONE);
        add_result(drfe_pkg::CH_RBRACE, drfe_pkg::KIND_RECORD_END, 8'h00, 8'd0,
                   drfe_pkg::ERR_NONE);
        add_byte(8'h23);
        add_result(drfe_pkg::CH_END, drfe_pkg::KIND_OK, 8'h00, 8'd0, drfe_pkg::ERR_NONE);

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                settle();
                write_reg(script[i].reg_idx, script[i].value);
            end else begin
                push_byte(script[i]);
            end
        end

        phase_no = 0;
        while (sent_bytes < BYTE_TARGET) begin
            settle();
            case (phase_no)
                0: begin rc = 8'd255; pl = 8'd63; tl = 8'd63; end
                1: begin rc = 8'd1;   pl = 8'd63; tl = 8'd1;  end
                2: begin rc = 8'd2;   pl = 8'd1;  tl = 8'd63; end
                default: begin
                    rc = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255))
                                                     : 8'($urandom_range(1, 4));
                    pl = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 8))
                                                     : 8'($urandom_range(1, 63));
                    tl = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(1, 8))
                                                     : 8'($urandom_range(1, 63));
                end
            endcase
            write_reg(drfe_pkg::CFG_RECORD_COUNT, rc);
            write_reg(drfe_pkg::CFG_PRICE_LIMIT, pl);
            write_reg(drfe_pkg::CFG_TIME_LIMIT, tl);
            if (phase_no % 4 == 3) write_reg(CFG_SPARE, 8'($urandom_range(0, 255)));
            phase_mark = sent_bytes;
            while (sent_bytes < phase_mark + 120 && sent_bytes < BYTE_TARGET) begin
                if (sent_bytes < BYTE_TARGET / 3) begin
                    src_idle_pct   = 17;
                    sink_stall_pct = 61;
                end else if (sent_bytes < 2 * BYTE_TARGET / 3) begin
                    src_idle_pct   = 61;
                    sink_stall_pct = 17;
                end else begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                build_response(resp);
                foreach (resp[i]) begin
                    row = '{is_cfg: 1'b0, reg_idx: 2'd0, value: resp[i], typed: 1'b0,
                            want: '0};
                    push_byte(row);
                end
            end
            phase_no++;
        end

        settle();
        $display("%0d responses closed (%0d ok, %0d failed), %0d results checked",
                 n_ok + n_failed, n_ok, n_failed, checked);
        $display("%0d bytes over %0d register settings, %0d register writes",
                 sent_bytes, phase_no + 2, cfg_writes);
        if (extracted_q.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, extracted_q.size());
        end
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
